FILE: rtl/clt_pkg.sv
// Shared constants, codes and interface types of the command line tokenizer.
package clt_pkg;

	// Line store and field table sizes.
	localparam int LINE_LIMIT  = 80;
	localparam int FIELD_LIMIT = 6;

	localparam int ADDR_W = $clog2(LINE_LIMIT);
	localparam int CNT_W  = $clog2(LINE_LIMIT + 1);
	localparam int FLD_W  = (FIELD_LIMIT > 1) ? $clog2(FIELD_LIMIT) : 1;
	localparam int FCNT_W = $clog2(FIELD_LIMIT + 1);

	// Fixed widths of the result fields.
	localparam int CNT_OUT_W = 3;
	localparam int IDX_OUT_W = 3;
	localparam int POS_OUT_W = 7;
	localparam int NUM_W     = 32;
	localparam int CHAR_W    = 7;

	// Character codes.
	localparam logic [7:0] CH_BS    = 8'd8;
	localparam logic [7:0] CH_DEL   = 8'd127;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_TILDE = 8'd126;

	typedef enum logic [1:0] {
		BY_OTHER,
		BY_BS,
		BY_CR,
		BY_PRINT
	} byte_cls_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH,
		ST_EMIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic append;
		logic backspace;
		logic finish;
		logic trunc;
		logic rd_issue;
		logic emit_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		byte_cls_t byte_cls;
		logic      full;
		logic      line_empty;
		logic      scan_last;
		logic      emit_last;
		logic      out_free;
	} sts_t;

	// One result item.
	typedef struct packed {
		logic                 valid;
		logic [CNT_OUT_W-1:0] count;
		logic [IDX_OUT_W-1:0] index;
		logic                 kind;
		logic [POS_OUT_W-1:0] start;
		logic [POS_OUT_W-1:0] length;
		logic [NUM_W-1:0]     number;
		logic [POS_OUT_W-1:0] line_len;
		logic                 trunc;
		logic                 last;
	} res_t;

endpackage

FILE: rtl/clt_ctrl.sv
// Controller state machine of the command line tokenizer.
module clt_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  clt_pkg::sts_t  sts,
	output clt_pkg::cmd_t  cmd
);

	clt_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= clt_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		s_tready  = 1'b0;
		case (state_q)
			clt_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					case (sts.byte_cls)
						clt_pkg::BY_BS: begin
							cmd.backspace = 1'b1;
						end
						clt_pkg::BY_CR: begin
							cmd.finish = 1'b1;
							state_nxt  = clt_pkg::ST_SCAN;
						end
						clt_pkg::BY_PRINT: begin
							// A printable byte on a full line is dropped and closes the line.
							if (sts.full) begin
								cmd.finish = 1'b1;
								cmd.trunc  = 1'b1;
								state_nxt  = clt_pkg::ST_SCAN;
							end else begin
								cmd.append = 1'b1;
							end
						end
						default: begin
						end
					endcase
				end
			end
			clt_pkg::ST_SCAN: begin
				if (sts.line_empty) begin
					state_nxt = clt_pkg::ST_FLUSH;
				end else begin
					cmd.rd_issue = 1'b1;
					if (sts.scan_last) begin
						state_nxt = clt_pkg::ST_FLUSH;
					end
				end
			end
			clt_pkg::ST_FLUSH: begin
				state_nxt = clt_pkg::ST_EMIT;
			end
			clt_pkg::ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit_load = 1'b1;
					if (sts.emit_last) begin
						state_nxt = clt_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_nxt = clt_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/clt_dp.sv
// Datapath of the command line tokenizer: line store, scan unit, field tables, result register.
module clt_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [7:0]     s_tdata,
	input  clt_pkg::cmd_t  cmd,
	output clt_pkg::sts_t  sts,
	input  logic           m_tready,
	output logic           m_tvalid,
	output clt_pkg::res_t  res
);

	localparam int ADDR_W = clt_pkg::ADDR_W;
	localparam int CNT_W  = clt_pkg::CNT_W;
	localparam int FLD_W  = clt_pkg::FLD_W;
	localparam int FCNT_W = clt_pkg::FCNT_W;
	localparam int NUM_W  = clt_pkg::NUM_W;
	localparam int CHAR_W = clt_pkg::CHAR_W;

	// Line store.
	logic [CHAR_W-1:0] line_mem [clt_pkg::LINE_LIMIT];

	logic [CNT_W-1:0]  char_cnt_q;
	logic [CNT_W-1:0]  len_q;
	logic              trunc_q;

	// Scan read pipeline.
	logic [ADDR_W-1:0] rd_addr_q;
	logic [CHAR_W-1:0] rd_data_s1;
	logic [ADDR_W-1:0] rd_pos_s1;
	logic              rd_vld_s1;

	// Field recognition state.
	logic              prev_delim_q;
	logic              in_run_q;
	logic              dig_on_q;
	logic [FCNT_W-1:0] nfields_q;
	logic [FLD_W-1:0]  cur_q;
	logic [CNT_W-1:0]  run_len_q;
	logic [NUM_W-1:0]  num_acc_q;

	logic [ADDR_W-1:0] start_tab [clt_pkg::FIELD_LIMIT];
	logic              kind_tab  [clt_pkg::FIELD_LIMIT];
	logic [CNT_W-1:0]  len_tab   [clt_pkg::FIELD_LIMIT];
	logic [NUM_W-1:0]  num_tab   [clt_pkg::FIELD_LIMIT];

	logic [FLD_W-1:0]  emit_idx_q;
	logic              m_tvalid_q;
	clt_pkg::res_t     res_q;

	// Classification of the character leaving the read stage.
	logic              is_letter, is_numeric, is_digit, is_field_char, new_fld;
	logic [NUM_W-1:0]  num_next;
	logic [FLD_W-1:0]  new_idx;

	always_comb begin
		is_letter     = ({1'b0, rd_data_s1} inside {[8'd65:8'd90], [8'd97:8'd122]});
		is_digit      = ({1'b0, rd_data_s1} inside {[8'd48:8'd57]});
		is_numeric    = is_digit || ({1'b0, rd_data_s1} inside {8'd45, 8'd46});
		is_field_char = is_letter || is_numeric;
		new_fld       = prev_delim_q && is_field_char
			&& (nfields_q != FCNT_W'(clt_pkg::FIELD_LIMIT));
		new_idx       = FLD_W'(nfields_q);
		num_next      = (num_acc_q << 3) + (num_acc_q << 1) + NUM_W'(rd_data_s1[3:0]);
	end

	// Status toward the controller.
	always_comb begin
		if (s_tdata == clt_pkg::CH_BS || s_tdata == clt_pkg::CH_DEL) begin
			sts.byte_cls = clt_pkg::BY_BS;
		end else if (s_tdata == clt_pkg::CH_CR) begin
			sts.byte_cls = clt_pkg::BY_CR;
		end else if (s_tdata >= clt_pkg::CH_SPACE && s_tdata <= clt_pkg::CH_TILDE) begin
			sts.byte_cls = clt_pkg::BY_PRINT;
		end else begin
			sts.byte_cls = clt_pkg::BY_OTHER;
		end
		sts.full       = (char_cnt_q == CNT_W'(clt_pkg::LINE_LIMIT));
		sts.line_empty = (len_q == '0);
		sts.scan_last  = ((CNT_W'(rd_addr_q) + CNT_W'(1)) == len_q);
		sts.emit_last  = (nfields_q == '0)
			|| ((FCNT_W'(emit_idx_q) + FCNT_W'(1)) == nfields_q);
		sts.out_free   = !m_tvalid_q || m_tready;
	end

	// Line store write and registered read.
	always_ff @(posedge clk) begin
		if (cmd.append) begin
			line_mem[ADDR_W'(char_cnt_q)] <= s_tdata[CHAR_W-1:0];
		end
		if (cmd.rd_issue) begin
			rd_data_s1 <= line_mem[rd_addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_cnt_q   <= '0;
			len_q        <= '0;
			trunc_q      <= 1'b0;
			rd_addr_q    <= '0;
			rd_vld_s1    <= 1'b0;
			prev_delim_q <= 1'b1;
			in_run_q     <= 1'b0;
			dig_on_q     <= 1'b0;
			nfields_q    <= '0;
			cur_q        <= '0;
			emit_idx_q   <= '0;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (cmd.append) begin
				char_cnt_q <= char_cnt_q + CNT_W'(1);
			end else if (cmd.backspace && char_cnt_q != '0) begin
				char_cnt_q <= char_cnt_q - CNT_W'(1);
			end else if (cmd.finish) begin
				char_cnt_q <= '0;
			end

			rd_vld_s1 <= cmd.rd_issue;
			if (cmd.finish) begin
				len_q        <= char_cnt_q;
				trunc_q      <= cmd.trunc;
				rd_addr_q    <= '0;
				prev_delim_q <= 1'b1;
				in_run_q     <= 1'b0;
				dig_on_q     <= 1'b0;
				nfields_q    <= '0;
				emit_idx_q   <= '0;
			end else begin
				if (cmd.rd_issue) begin
					rd_addr_q <= rd_addr_q + ADDR_W'(1);
				end
				if (rd_vld_s1) begin
					prev_delim_q <= !is_field_char;
					if (new_fld) begin
						nfields_q <= nfields_q + FCNT_W'(1);
						cur_q     <= new_idx;
						in_run_q  <= 1'b1;
						dig_on_q  <= is_digit;
					end else if (!is_field_char) begin
						in_run_q <= 1'b0;
					end else if (in_run_q && !(dig_on_q && is_digit)) begin
						dig_on_q <= 1'b0;
					end
				end
				if (cmd.emit_load) begin
					emit_idx_q <= emit_idx_q + FLD_W'(1);
				end
			end

			if (cmd.emit_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Field tables and run accumulators.
	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			if (new_fld) begin
				start_tab[new_idx] <= rd_pos_s1;
				kind_tab[new_idx]  <= is_numeric;
				len_tab[new_idx]   <= CNT_W'(1);
				num_tab[new_idx]   <= is_digit ? NUM_W'(rd_data_s1[3:0]) : '0;
				run_len_q          <= CNT_W'(1);
				num_acc_q          <= is_digit ? NUM_W'(rd_data_s1[3:0]) : '0;
			end else if (in_run_q && is_field_char) begin
				run_len_q      <= run_len_q + CNT_W'(1);
				len_tab[cur_q] <= run_len_q + CNT_W'(1);
				if (dig_on_q && is_digit) begin
					num_acc_q      <= num_next;
					num_tab[cur_q] <= num_next;
				end
			end
		end
		rd_pos_s1 <= rd_addr_q;
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.emit_load) begin
			res_q          <= '0;
			res_q.line_len <= clt_pkg::POS_OUT_W'(len_q);
			res_q.trunc    <= trunc_q;
			res_q.last     <= sts.emit_last;
			if (nfields_q != '0) begin
				res_q.valid  <= 1'b1;
				res_q.count  <= clt_pkg::CNT_OUT_W'(nfields_q);
				res_q.index  <= clt_pkg::IDX_OUT_W'(emit_idx_q);
				res_q.kind   <= kind_tab[emit_idx_q];
				res_q.start  <= clt_pkg::POS_OUT_W'(start_tab[emit_idx_q]);
				res_q.number <= num_tab[emit_idx_q];
				if (emit_idx_q == FLD_W'(clt_pkg::FIELD_LIMIT - 1)) begin
					res_q.length <= clt_pkg::POS_OUT_W'(len_q - CNT_W'(start_tab[emit_idx_q]));
				end else begin
					res_q.length <= clt_pkg::POS_OUT_W'(len_tab[emit_idx_q]);
				end
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign res      = res_q;

	a_char_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		char_cnt_q <= CNT_W'(clt_pkg::LINE_LIMIT))
		else $error("character count beyond line store");

	a_field_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nfields_q <= FCNT_W'(clt_pkg::FIELD_LIMIT))
		else $error("field count beyond table depth");

	a_scan_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (CNT_W'(rd_pos_s1) < len_q))
		else $error("scan read beyond line end");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_load |-> (!m_tvalid_q || m_tready))
		else $error("result register loaded while a request waits");

	a_quiet_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_issue |-> !(cmd.append || cmd.finish || cmd.emit_load))
		else $error("scan overlaps line collection or emission");

endmodule

FILE: rtl/command_line_tokenizer.sv
// Top level of the command line tokenizer: controller, datapath and stream ports.
// Bytes are taken one per cycle while a line is collected; a byte that does not end the line
// produces no result. A line end starts the scan, which reads one stored character a cycle,
// then the emission of the line's results, one per cycle while the sink keeps m_tready high.
// The asynchronous reset clears the character count and all control state; the line store
// and field tables are not cleared, since only written entries are ever read.
module command_line_tokenizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [2:0] field_count, [5:3] field_index, [6] field_kind,
	                               // [13:7] field_start, [20:14] field_length,
	                               // [52:21] field_number, [59:53] line_length,
	                               // [60] line_truncated, [63:61] zero
	output logic        m_tuser,   // [0] field_valid
	output logic        m_tlast
);

	clt_pkg::cmd_t cmd;
	clt_pkg::sts_t sts;
	clt_pkg::res_t res;

	// The controller accepts a request only while idle. It turns each byte into an append,
	// a backspace, a line end or nothing, then walks the scan and emission of the line's results.
	clt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath holds the line store and the field tables. The scan records the start, kind,
	// run length and leading decimal value of up to six fields in a single pass over the line. The
	// result register lets a new line be collected while the last result still waits.
	clt_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.cmd      (cmd),
		.sts      (sts),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.res      (res)
	);

	// Pack the result, first field in the lowest bits, padded with zeros to whole bytes.
	assign m_tdata = {3'b000, res.trunc, res.line_len, res.number, res.length, res.start,
		res.kind, res.index, res.count};
	assign m_tuser = res.valid;
	assign m_tlast = res.last;

endmodule

FILE: tb/sv/command_line_tokenizer_checker.sv
`timescale 1ns / 100ps
// Checker for the command line tokenizer: follows accepted bytes, predicts fields, compares results.
module command_line_tokenizer_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [63:0] m_tdata,
	input  logic        m_tuser,
	input  logic        m_tlast,
	output int          failures,
	output int          outstanding
);

	localparam int REPORT_LIMIT = 10;

	localparam logic [7:0] CH_ZERO  = "0";
	localparam logic [7:0] CH_NINE  = "9";
	localparam logic [7:0] CH_MINUS = "-";
	localparam logic [7:0] CH_POINT = ".";
	localparam logic [7:0] CH_UP_A  = "A";
	localparam logic [7:0] CH_UP_Z  = "Z";
	localparam logic [7:0] CH_LO_A  = "a";
	localparam logic [7:0] CH_LO_Z  = "z";

	typedef enum logic [1:0] {
		CK_DELIM,
		CK_LETTER,
		CK_NUMERIC
	} char_kind_t;

	typedef struct packed {
		logic        valid;
		logic [2:0]  count;
		logic [2:0]  index;
		logic        kind;
		logic [6:0]  start;
		logic [6:0]  length;
		logic [31:0] number;
		logic [6:0]  line_len;
		logic        trunc;
		logic        last;
	} field_rec_t;

	logic [6:0]  line_chars [clt_pkg::LINE_LIMIT];
	int unsigned stored_len;
	field_rec_t  field_queue [$];

	function automatic char_kind_t kind_of(input logic [6:0] ch);
		logic [7:0] c;
		c = {1'b0, ch};
		if ((c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z))
			return CK_LETTER;
		if ((c >= CH_ZERO && c <= CH_NINE) || c == CH_MINUS || c == CH_POINT)
			return CK_NUMERIC;
		return CK_DELIM;
	endfunction

	function automatic bit is_digit(input logic [6:0] ch);
		return {1'b0, ch} >= CH_ZERO && {1'b0, ch} <= CH_NINE;
	endfunction

	// Splits the line into fields, queues one expected result per field (one empty one if none).
	task automatic close_line(input bit truncated);
		int unsigned starts [clt_pkg::FIELD_LIMIT];
		char_kind_t  kinds [clt_pkg::FIELD_LIMIT];
		int unsigned nfields;
		int unsigned pos;
		int unsigned stop;
		bit          after_delim;
		logic [31:0] value;
		field_rec_t  rec;
		nfields = 0;
		after_delim = 1'b1;
		for (pos = 0; pos < stored_len && nfields < clt_pkg::FIELD_LIMIT; pos++) begin
			if (after_delim && kind_of(line_chars[pos]) != CK_DELIM) begin
				starts[nfields] = pos;
				kinds[nfields] = kind_of(line_chars[pos]);
				nfields++;
			end
			after_delim = (kind_of(line_chars[pos]) == CK_DELIM);
		end
		if (nfields == 0) begin
			rec = '0;
			rec.line_len = stored_len[6:0];
			rec.trunc = truncated;
			rec.last = 1'b1;
			field_queue.push_back(rec);
		end
		for (int k = 0; k < nfields; k++) begin
			// The last field that fits in the table takes the rest of the line.
			if (k == clt_pkg::FIELD_LIMIT - 1) begin
				stop = stored_len;
			end else begin
				stop = starts[k];
				while (stop < stored_len && kind_of(line_chars[stop]) != CK_DELIM)
					stop++;
			end
			value = '0;
			if (kinds[k] == CK_NUMERIC) begin
				pos = starts[k];
				while (pos < stored_len && is_digit(line_chars[pos])) begin
					value = value * 32'd10 + 32'({1'b0, line_chars[pos]} - CH_ZERO);
					pos++;
				end
			end
			rec.valid = 1'b1;
			rec.count = nfields[2:0];
			rec.index = k[2:0];
			rec.kind = (kinds[k] == CK_NUMERIC);
			rec.start = starts[k][6:0];
			rec.length = 7'(stop - starts[k]);
			rec.number = value;
			rec.line_len = stored_len[6:0];
			rec.trunc = truncated;
			rec.last = (k == nfields - 1);
			field_queue.push_back(rec);
		end
		stored_len = 0;
	endtask

	task automatic take_byte(input logic [7:0] b);
		if (b == clt_pkg::CH_BS || b == clt_pkg::CH_DEL) begin
			if (stored_len > 0)
				stored_len--;
		end else if (b == clt_pkg::CH_CR) begin
			close_line(1'b0);
		end else if (b >= clt_pkg::CH_SPACE && b <= clt_pkg::CH_TILDE) begin
			if (stored_len < clt_pkg::LINE_LIMIT) begin
				line_chars[stored_len] = b[6:0];
				stored_len++;
			end else begin
				close_line(1'b1);
			end
		end
	endtask

	task automatic check_result();
		field_rec_t want;
		field_rec_t got;
		got.valid = m_tuser;
		got.count = m_tdata[2:0];
		got.index = m_tdata[5:3];
		got.kind = m_tdata[6];
		got.start = m_tdata[13:7];
		got.length = m_tdata[20:14];
		got.number = m_tdata[52:21];
		got.line_len = m_tdata[59:53];
		got.trunc = m_tdata[60];
		got.last = m_tlast;
		if (field_queue.size() == 0) begin
			if (failures < REPORT_LIMIT)
				$display("%0t: unexpected result valid=%0b count=%0d index=%0d", $realtime,
					got.valid, got.count, got.index);
			failures++;
			return;
		end
		want = field_queue.pop_front();
		if (got !== want || m_tdata[63:61] !== 3'b000) begin
			if (failures < REPORT_LIMIT) begin
				$display("%0t: result mismatch (valid count index kind start len num line %s",
					$realtime, "trunc last pad)");
				$display("  expected %0b %0d %0d %0b %0d %0d %0d %0d %0b %0b 0", want.valid,
					want.count, want.index, want.kind, want.start, want.length, want.number,
					want.line_len, want.trunc, want.last);
				$display("  actual   %0b %0d %0d %0b %0d %0d %0d %0d %0b %0b %0d", got.valid,
					got.count, got.index, got.kind, got.start, got.length, got.number,
					got.line_len, got.trunc, got.last, m_tdata[63:61]);
			end
			failures++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_len = 0;
			field_queue.delete();
			failures = 0;
			outstanding = 0;
		end else begin
			if (m_tvalid && m_tready)
				check_result();
			if (s_tvalid && s_tready)
				take_byte(s_tdata);
			outstanding = field_queue.size();
		end
	end

endmodule

FILE: tb/sv/command_line_tokenizer_tb.sv
`timescale 1ns / 100ps
// Testbench top for the command line tokenizer: byte stimulus, result sink, watchdog and verdict.
module command_line_tokenizer_tb;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_CYCLES    = 400;
	localparam int RANDOM_ITEMS   = 250;
	localparam int CALM_AFTER     = 190;
	localparam int DRAIN_CYCLES   = 100;

	typedef enum logic [1:0] {
		LN_PLAIN,
		LN_TOKENS,
		LN_OVERFLOW
	} line_mode_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	int failures;
	int outstanding;
	int random_items;
	int quiet_cycles;
	bit idling_on;
	bit hold_request;

	command_line_tokenizer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	command_line_tokenizer_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast),
		.failures    (failures),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		idling_on = 1'b1;
		hold_request = 1'b0;
		random_items = 0;
	end

	always #5 clk = ~clk;

	// Ends the run when neither side has moved a request for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Result sink: random stall bursts, one long hold-off while the sender keeps going.
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (idling_on && $urandom_range(0, 7) == 0) begin
				gap = $urandom_range(1, 7);
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Offers one byte and returns at the edge where the request is taken.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (idling_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 7);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	function automatic logic [7:0] pick_char(input line_mode_t mode);
		int r;
		r = $urandom_range(0, 99);
		if (mode == LN_TOKENS && r < 45)
			return clt_pkg::CH_SPACE;
		if (r < 30)
			return $urandom_range(0, 1) ? 8'($urandom_range("A", "Z"))
			                            : 8'($urandom_range("a", "z"));
		if (r < 55)
			return 8'($urandom_range("0", "9"));
		if (r < 60)
			return $urandom_range(0, 1) ? "-" : ".";
		if (r < 75)
			return clt_pkg::CH_SPACE;
		if (r < 85)
			return 8'($urandom_range(clt_pkg::CH_SPACE, clt_pkg::CH_TILDE));
		// Overflow lines stay printable so that the store really fills.
		if (mode == LN_OVERFLOW)
			return 8'($urandom_range("a", "z"));
		if (r < 92)
			return $urandom_range(0, 1) ? clt_pkg::CH_BS : clt_pkg::CH_DEL;
		return 8'($urandom_range(0, 255));
	endfunction

	// Sends one line of random content followed by a carriage return.
	task automatic send_line(input line_mode_t mode);
		int n;
		logic [7:0] c;
		case (mode)
			LN_TOKENS:   n = $urandom_range(8, 30);
			LN_OVERFLOW: n = $urandom_range(clt_pkg::LINE_LIMIT + 1, clt_pkg::LINE_LIMIT + 10);
			default:     n = $urandom_range(0, 24);
		endcase
		for (int i = 0; i < n; i++) begin
			c = pick_char(mode);
			send_byte(c);
			if (c == clt_pkg::CH_BS || c == clt_pkg::CH_DEL || c == clt_pkg::CH_CR
				|| (c >= clt_pkg::CH_SPACE && c <= clt_pkg::CH_TILDE))
				random_items++;
		end
		send_byte(clt_pkg::CH_CR);
		random_items++;
	endtask

	initial begin
		line_mode_t mode;
		int line_no;
		int r;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed lines: backspace with nothing stored, an empty line, ignored bytes,
		// a mixed line with a delete, a line of delimiters only and a wrapping number.
		send_byte(clt_pkg::CH_BS);
		send_byte(clt_pkg::CH_CR);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_text("a9 -3");
		send_byte(clt_pkg::CH_DEL);
		send_text("42 Z 7x");
		send_byte(clt_pkg::CH_CR);
		send_text(" ;");
		send_byte(clt_pkg::CH_CR);
		send_text("4294967299");
		send_byte(clt_pkg::CH_CR);

		// Random lines; the sink holds off for a long stretch right at the start.
		hold_request = 1'b1;
		line_no = 0;
		while (random_items < RANDOM_ITEMS) begin
			if (random_items >= CALM_AFTER)
				idling_on = 1'b0;
			r = $urandom_range(0, 9);
			if (line_no == 0 || r == 0)
				mode = LN_OVERFLOW;
			else if (line_no == 1 || r < 4)
				mode = LN_TOKENS;
			else
				mode = LN_PLAIN;
			send_line(mode);
			line_no++;
		end
		s_tvalid <= 1'b0;

		@(posedge clk);
		wait (outstanding == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
